// ===== design/krt_pkg.sv =====
`default_nettype none
package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_BYTES_DEF   = 8;

  // field widths of the request and response channels
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 64;
  localparam int PRICE_W  = 32;
  localparam int VALUE_W  = 31;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage
`default_nettype wire

// ===== design/krt_if.sv =====
`default_nettype none
interface krt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [krt_pkg::REQ_W-1:0]              req_type;
  logic [krt_pkg::KEY_W-1:0]              key;
  logic signed [krt_pkg::PRICE_W-1:0]     price;
  logic [krt_pkg::POS_W-1:0]              position;

  modport source (output valid, req_type, key, price, position, input ready);
  modport sink   (input valid, req_type, key, price, position, output ready);
endinterface

interface krt_out_if;
  logic                           valid;
  logic                           ready;
  logic [krt_pkg::STATUS_W-1:0]   status;
  logic [krt_pkg::POS_W-1:0]      hit_position;
  logic [krt_pkg::KEY_W-1:0]      key_out;
  logic [krt_pkg::VALUE_W-1:0]    price_out;
  logic [krt_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, status, hit_position, key_out, price_out, entry_count,
                  input ready);
  modport sink   (input valid, status, hit_position, key_out, price_out, entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== design/krt_ram.sv =====
`default_nettype none
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/keyed_record_table.sv =====
`default_nettype none
// Append and rejected requests go straight to the result state; a read passes
// through S_READ first; update/delete scan the table one entry per RAM read,
// and a delete then shifts the records above the hit down one place.
// One request at a time: ready is high only in idle, so a new request is taken
// only after the previous response has been loaded into the output register.
// Reset: synchronous active-low rst_n empties the table (count 0); RAM not cleared.
module keyed_record_table_core #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = krt_pkg::KEY_BYTES_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  krt_in_if.sink      in_req,
  krt_out_if.source   out_rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = 8 * KEY_BYTES;
  localparam int VW    = krt_pkg::VALUE_W;
  localparam int CMP_W = (CNT_W > krt_pkg::POS_W) ? CNT_W : krt_pkg::POS_W;
  localparam int MEM_W = KW + VW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SHIFT,
    S_RESULT
  } state_t;

  // control
  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  krt_pkg::req_t               op_r, op_nxt;
  logic [CNT_W-1:0]            scan_r, scan_nxt;     // scan read pointer, also shift source
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic                        shv_r, shv_nxt;       // shift data arriving from RAM
  logic [IDX_W-1:0]            shw_r, shw_nxt;       // shift write destination
  logic                        out_valid_r, out_valid_nxt;

  // payload
  logic [KW-1:0]                    key_r, key_nxt;
  logic [VW-1:0]                    price_r, price_nxt;
  logic [krt_pkg::STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [IDX_W-1:0]                 res_hit_r, res_hit_nxt;
  logic [KW-1:0]                    res_key_r, res_key_nxt;
  logic [VW-1:0]                    res_price_r, res_price_nxt;
  logic [krt_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [krt_pkg::POS_W-1:0]        out_hit_r, out_hit_nxt;
  logic [krt_pkg::KEY_W-1:0]        out_key_r, out_key_nxt;
  logic [VW-1:0]                    out_price_r, out_price_nxt;
  logic [krt_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;

  // record RAM: {key, price} per entry
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [MEM_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [MEM_W-1:0] ram_rdata;
  logic [KW-1:0]    rd_key;
  logic [VW-1:0]    rd_price;

  logic             accept;
  logic             neg;
  logic             issue;
  logic             last_cmp;

  krt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[MEM_W-1:VW];
  assign rd_price = ram_rdata[VW-1:0];

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign neg          = in_req.price[krt_pkg::PRICE_W-1];

  assign issue    = (scan_r < count_r);
  // the entry under compare is the last live one
  assign last_cmp = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.hit_position = out_hit_r;
  assign out_rsp.key_out      = out_key_r;
  assign out_rsp.price_out    = out_price_r;
  assign out_rsp.entry_count  = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    shv_nxt        = shv_r;
    shw_nxt        = shw_r;
    out_valid_nxt  = out_valid_r;
    key_nxt        = key_r;
    price_nxt      = price_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_key_nxt    = res_key_r;
    res_price_nxt  = res_price_r;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_key_nxt    = out_key_r;
    out_price_nxt  = out_price_r;
    out_count_nxt  = out_count_r;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = scan_r[IDX_W-1:0];

    // response taken downstream frees the output register
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = in_req.key[KW-1:0];   // only KEY_BYTES bytes count
          price_nxt      = in_req.price[VW-1:0];
          op_nxt         = krt_pkg::req_t'(in_req.req_type);
          res_status_nxt = krt_pkg::ST_OK;
          res_hit_nxt    = '0;
          res_key_nxt    = '0;
          res_price_nxt  = '0;
          scan_nxt       = '0;
          cmp_vld_nxt    = 1'b0;
          shv_nxt        = 1'b0;
          state_nxt      = S_RESULT;
          case (krt_pkg::req_t'(in_req.req_type))
            krt_pkg::REQ_APPEND: begin
              if (neg) begin
                res_status_nxt = krt_pkg::ST_NEGATIVE;
              end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = krt_pkg::ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = count_r[IDX_W-1:0];
                ram_wdata   = {in_req.key[KW-1:0], in_req.price[VW-1:0]};
                res_hit_nxt = count_r[IDX_W-1:0];
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            krt_pkg::REQ_UPDATE: begin
              if (neg) begin
                res_status_nxt = krt_pkg::ST_NEGATIVE;
              end else if (count_r == '0) begin
                res_status_nxt = krt_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            krt_pkg::REQ_DELETE: begin
              // price is ignored on delete
              if (count_r == '0) begin
                res_status_nxt = krt_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              if (CMP_W'(in_req.position) >= CMP_W'(count_r)) begin
                res_status_nxt = krt_pkg::ST_EMPTY;
              end else begin
                ram_raddr   = IDX_W'(in_req.position);
                res_hit_nxt = IDX_W'(in_req.position);
                state_nxt   = S_READ;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        // one read issued per cycle, each entry compared in the cycle after its read
        cmp_vld_nxt = issue;
        cmp_idx_nxt = scan_r[IDX_W-1:0];
        if (issue) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        if (cmp_vld_r) begin
          if (rd_key == key_r) begin
            res_hit_nxt = cmp_idx_r;
            cmp_vld_nxt = 1'b0;
            if (op_r == krt_pkg::REQ_UPDATE) begin
              ram_we    = 1'b1;
              ram_waddr = cmp_idx_r;
              ram_wdata = {rd_key, price_r};
              state_nxt = S_RESULT;
            end else begin
              // close the gap: move entries above the hit down one place
              scan_nxt  = CNT_W'(cmp_idx_r) + CNT_W'(1);
              shv_nxt   = 1'b0;
              state_nxt = S_SHIFT;
            end
          end else if (last_cmp) begin
            res_status_nxt = krt_pkg::ST_NOT_FOUND;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_RESULT;
          end
        end
      end

      S_SHIFT: begin
        if (shv_r) begin
          ram_we    = 1'b1;
          ram_waddr = shw_r;
          ram_wdata = ram_rdata;
        end
        if (issue) begin
          shv_nxt  = 1'b1;
          shw_nxt  = IDX_W'(scan_r - CNT_W'(1));
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          shv_nxt = 1'b0;
          if (!shv_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESULT;
          end
        end
      end

      S_READ: begin
        res_key_nxt   = rd_key;
        res_price_nxt = rd_price;
        state_nxt     = S_RESULT;
      end

      S_RESULT: begin
        // wait here only while the previous response is still held
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = krt_pkg::POS_W'(res_hit_r);
          out_key_nxt    = krt_pkg::KEY_W'(res_key_r);
          out_price_nxt  = res_price_r;
          out_count_nxt  = krt_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      op_r        <= krt_pkg::REQ_APPEND;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      shv_r       <= 1'b0;
      shw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      op_r         <= op_nxt;
      scan_r       <= scan_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      shv_r        <= shv_nxt;
      shw_r        <= shw_nxt;
      out_valid_r  <= out_valid_nxt;
      key_r        <= key_nxt;
      price_r      <= price_nxt;
      res_status_r <= res_status_nxt;
      res_hit_r    <= res_hit_nxt;
      res_key_r    <= res_key_nxt;
      res_price_r  <= res_price_nxt;
      out_status_r <= out_status_nxt;
      out_hit_r    <= out_hit_nxt;
      out_key_r    <= out_key_nxt;
      out_price_r  <= out_price_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH     = krt_pkg::TABLE_DEPTH_DEF;
  localparam int NAME_LEN  = krt_pkg::KEY_BYTES_DEF;
  // only the low NAME_LEN bytes of a key take part in a match
  localparam logic [krt_pkg::KEY_W-1:0] KEY_MASK =
      (NAME_LEN >= 8) ? {krt_pkg::KEY_W{1'b1}} : ((64'd1 << (8 * NAME_LEN)) - 64'd1);
  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_ITEMS = 1830;
  // worst single request: full scan plus a shift of the whole table, plus stalls
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 300;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_READS} mix_t;

  // one request as the sender sees it; hold_off makes the sender wait for
  // every outstanding response before this one goes out
  typedef struct {
    krt_pkg::req_t                       kind;
    logic [krt_pkg::KEY_W-1:0]           key;
    logic signed [krt_pkg::PRICE_W-1:0]  price;
    logic [krt_pkg::POS_W-1:0]           pos;
    bit                                  hold_off;
  } table_req_t;

  typedef struct {
    logic [krt_pkg::STATUS_W-1:0] status;
    logic [krt_pkg::POS_W-1:0]    hit;
    logic [krt_pkg::KEY_W-1:0]    key;
    logic [krt_pkg::VALUE_W-1:0]  price;
    logic [krt_pkg::COUNT_W-1:0]  count;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  krt_in_if  req_bus ();
  krt_out_if rsp_bus ();

  keyed_record_table_core #(
    .TABLE_DEPTH (DEPTH),
    .KEY_BYTES   (NAME_LEN)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus.sink),
    .out_rsp (rsp_bus.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the record table
  logic [krt_pkg::KEY_W-1:0]   rec_keys   [DEPTH];
  logic [krt_pkg::VALUE_W-1:0] rec_prices [DEPTH];
  int                          rec_count;

  table_req_t requests_to_send [$];
  table_rsp_t responses_due    [$];
  logic [krt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  table_req_t in_flight;
  int  send_gap, send_calm, recv_gap, recv_calm;
  int  mismatches;
  int  quiet_cycles;

  // Apply one request to the shadow table and return the response it should give.
  function automatic table_rsp_t table_apply(table_req_t r);
    table_rsp_t                  rsp;
    logic [krt_pkg::KEY_W-1:0]   k;
    bit                          neg;
    logic [krt_pkg::VALUE_W-1:0] val;
    int                          idx;
    int                          i;
    rsp = '{krt_pkg::ST_OK, '0, '0, '0, '0};
    k   = r.key & KEY_MASK;
    neg = r.price[krt_pkg::PRICE_W-1];
    val = r.price[krt_pkg::VALUE_W-1:0];
    // lowest matching position, -1 if none
    idx = -1;
    for (i = rec_count - 1; i >= 0; i--)
      if (rec_keys[i] == k) idx = i;
    case (r.kind)
      krt_pkg::REQ_APPEND: begin
        if (neg) begin
          rsp.status = krt_pkg::ST_NEGATIVE;
        end else if (rec_count >= DEPTH) begin
          rsp.status = krt_pkg::ST_FULL;
        end else begin
          rec_keys[rec_count]   = k;
          rec_prices[rec_count] = val;
          rsp.hit   = rec_count[krt_pkg::POS_W-1:0];
          rec_count = rec_count + 1;
        end
      end
      krt_pkg::REQ_UPDATE: begin
        // negative check wins over the search
        if (neg) begin
          rsp.status = krt_pkg::ST_NEGATIVE;
        end else if (idx < 0) begin
          rsp.status = krt_pkg::ST_NOT_FOUND;
        end else begin
          rec_prices[idx] = val;
          rsp.hit = idx[krt_pkg::POS_W-1:0];
        end
      end
      krt_pkg::REQ_DELETE: begin
        // price ignored; later records close the gap
        if (idx < 0) begin
          rsp.status = krt_pkg::ST_NOT_FOUND;
        end else begin
          for (i = idx; i + 1 < rec_count; i++) begin
            rec_keys[i]   = rec_keys[i + 1];
            rec_prices[i] = rec_prices[i + 1];
          end
          rec_count = rec_count - 1;
          rsp.hit = idx[krt_pkg::POS_W-1:0];
        end
      end
      default: begin
        if (int'(r.pos) >= rec_count) begin
          rsp.status = krt_pkg::ST_EMPTY;
        end else begin
          rsp.key   = rec_keys[r.pos];
          rsp.price = rec_prices[r.pos];
          rsp.hit   = r.pos;
        end
      end
    endcase
    rsp.count = rec_count[krt_pkg::COUNT_W-1:0];
    return rsp;
  endfunction

  // Wait before the next request/response: mostly a random idle gap, now and then
  // a stretch with no idling at all.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 12);
  endfunction

  task automatic queue_request(krt_pkg::req_t kind, logic [krt_pkg::KEY_W-1:0] key,
                               logic signed [krt_pkg::PRICE_W-1:0] price,
                               logic [krt_pkg::POS_W-1:0] pos, bit hold_off);
    table_req_t r;
    r = '{kind, key, price, pos, hold_off};
    requests_to_send.push_back(r);
  endtask

  // name of 1..8 random bytes, first char in the low byte, zero padded
  function automatic logic [krt_pkg::KEY_W-1:0] make_name();
    logic [krt_pkg::KEY_W-1:0] name;
    int                        len;
    int                        b;
    name = '0;
    len  = $urandom_range(1, 8);
    for (b = 0; b < len; b++) name[8*b +: 8] = 8'($urandom_range(1, 255));
    return name;
  endfunction

  // pool keys give plenty of hits and duplicates; the rest are mostly misses
  function automatic logic [krt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [krt_pkg::PRICE_W-1:0] pick_price();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'sd0;
    if (roll == 1) return 32'sh7fff_ffff;
    if (roll <= 3) return $urandom() | 32'h8000_0000;
    return $urandom() & 32'h7fff_ffff;
  endfunction

  // reads aim mostly at the low end where records usually are
  function automatic logic [krt_pkg::POS_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return krt_pkg::POS_W'($urandom_range(0, 20));
    if (roll < 17) return krt_pkg::POS_W'($urandom_range(0, 127));
    return krt_pkg::POS_W'($urandom_range(100, 127));
  endfunction

  task automatic build_directed();
    logic [krt_pkg::KEY_W-1:0] ones;
    ones = {krt_pkg::KEY_W{1'b1}};
    // empty table: every lookup misses, every read is empty
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd5,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_UPDATE, 64'h41, 32'sd7,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_DELETE, 64'h41, 32'sd0,         7'd0,   1'b0);
    // negative value rejected before anything else
    queue_request(krt_pkg::REQ_APPEND, 64'h41, 32'sh8000_0000, 7'd0,   1'b0);
    // extremes of key and price, then a duplicate key
    queue_request(krt_pkg::REQ_APPEND, '0,     32'sd0,         7'd127, 1'b0);
    queue_request(krt_pkg::REQ_APPEND, ones,   32'sh7fff_ffff, 7'd0,   1'b0);
    queue_request(krt_pkg::REQ_APPEND, 64'h41, 32'sd12345,     7'd0,   1'b0);
    queue_request(krt_pkg::REQ_APPEND, ones,   32'sd1,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_READ,   ones,   -32'sd1,        7'd1,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd3,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd4,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd127, 1'b0);
    // update: negative, first of two matches, missing key
    queue_request(krt_pkg::REQ_UPDATE, ones,   -32'sd1,        7'd0,   1'b0);
    queue_request(krt_pkg::REQ_UPDATE, ones,   32'sh5555_5555, 7'd0,   1'b0);
    queue_request(krt_pkg::REQ_UPDATE, 64'h42, 32'sd9,         7'd0,   1'b0);
    // delete the first duplicate; the rest shift down
    queue_request(krt_pkg::REQ_DELETE, ones,   32'sd0,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd1,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd2,   1'b0);
    // delete ignores a negative price
    queue_request(krt_pkg::REQ_DELETE, '0,     32'sh8000_0000, 7'd0,   1'b0);
    queue_request(krt_pkg::REQ_DELETE, 64'h41, 32'sd3,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_DELETE, ones,   32'sd0,         7'd0,   1'b0);
    queue_request(krt_pkg::REQ_READ,   '0,     32'sd0,         7'd0,   1'b0);
  endtask

  // Random part in segments of differing mix; the first one fills the table
  // past full so appends get refused and deletes shift the whole table.
  task automatic build_random();
    mix_t          mix;
    int            made;
    int            seg_len;
    int            roll;
    int            n;
    krt_pkg::req_t kind;
    int            p;
    for (p = 0; p < POOL_SIZE; p++) key_pool[p] = make_name();
    key_pool[0] = '0;
    key_pool[1] = {krt_pkg::KEY_W{1'b1}};
    key_pool[2] = {$urandom(), $urandom()};
    made    = 0;
    mix     = MIX_FILL;
    seg_len = 220;
    while (made < RANDOM_ITEMS) begin
      for (n = 0; n < seg_len && made < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  kind = roll < 75 ? krt_pkg::REQ_APPEND :
                            roll < 85 ? krt_pkg::REQ_UPDATE :
                            roll < 90 ? krt_pkg::REQ_DELETE : krt_pkg::REQ_READ;
          MIX_CHURN: kind = roll < 30 ? krt_pkg::REQ_APPEND :
                            roll < 55 ? krt_pkg::REQ_UPDATE :
                            roll < 80 ? krt_pkg::REQ_DELETE : krt_pkg::REQ_READ;
          MIX_DRAIN: kind = roll < 5  ? krt_pkg::REQ_APPEND :
                            roll < 20 ? krt_pkg::REQ_UPDATE :
                            roll < 85 ? krt_pkg::REQ_DELETE : krt_pkg::REQ_READ;
          default:   kind = roll < 10 ? krt_pkg::REQ_APPEND :
                            roll < 20 ? krt_pkg::REQ_UPDATE :
                            roll < 30 ? krt_pkg::REQ_DELETE : krt_pkg::REQ_READ;
        endcase
        queue_request(kind, pick_key(), pick_price(), pick_pos(),
                      made == 0 || $urandom_range(0, 59) == 0);
        made++;
      end
      mix     = mix_t'($urandom_range(0, 3));
      seg_len = $urandom_range(40, 160);
    end
  endtask

  task automatic compare_field(string name, logic [krt_pkg::KEY_W-1:0] want,
                               logic [krt_pkg::KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: presents the queue head after the drawn gap, holds it until
  // accepted, and updates the shadow table at the accepting edge.
  always @(posedge clk) begin : drive_requests
    bit busy;
    bit launch;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      busy   = req_bus.valid;
      launch = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        responses_due.push_back(table_apply(in_flight));
        busy     = 1'b0;
        send_gap = draw_gap(send_calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (requests_to_send.size() > 0 &&
                     !(requests_to_send[0].hold_off && responses_due.size() > 0)) begin
          in_flight = requests_to_send.pop_front();
          launch    = 1'b1;
          req_bus.req_type <= in_flight.kind;
          req_bus.key      <= in_flight.key;
          req_bus.price    <= in_flight.price;
          req_bus.position <= in_flight.pos;
        end
      end
      // one assignment per edge: stays high across back-to-back requests
      req_bus.valid <= busy || launch;
    end
  end

  // Response monitor: random back-pressure, checks each response in order.
  always @(posedge clk) begin : watch_responses
    table_rsp_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      recv_gap  = 0;
      recv_calm = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (responses_due.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                   $time, rsp_bus.status, rsp_bus.entry_count);
          mismatches++;
        end else begin
          want = responses_due.pop_front();
          compare_field("status",       krt_pkg::KEY_W'(want.status),
                        krt_pkg::KEY_W'(rsp_bus.status));
          compare_field("hit_position", krt_pkg::KEY_W'(want.hit),
                        krt_pkg::KEY_W'(rsp_bus.hit_position));
          compare_field("key_out",      want.key, rsp_bus.key_out);
          compare_field("price_out",    krt_pkg::KEY_W'(want.price),
                        krt_pkg::KEY_W'(rsp_bus.price_out));
          compare_field("entry_count",  krt_pkg::KEY_W'(want.count),
                        krt_pkg::KEY_W'(rsp_bus.entry_count));
        end
        recv_gap = draw_gap(recv_calm);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      rsp_bus.ready <= (recv_gap == 0);
    end
  end

  // Watchdog: too long with no handshake on either side means a hang.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : run_control
    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.key      = '0;
    req_bus.price    = '0;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    rec_count        = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // all requests out, then every response back
    while (requests_to_send.size() > 0 || req_bus.valid || responses_due.size() > 0)
      @(posedge clk);
    // catch any stray response after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/krt_pkg.sv
design/krt_if.sv
design/krt_ram.sv
design/keyed_record_table.sv
test/testbench.sv
